// ===== rtl/lrd_pkg.sv =====
// package: types, constants and crc step for the log record deframer
package lrd_pkg;

  localparam int MAX_BODY_BYTES_DEF = 65536;
  localparam int RECORD_HEADER_BYTES = 17;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_LEN,
    PH_CRC,
    PH_BODY,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_STOP    = 2'd2
  } kind_t;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SKIPPED   = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_MAGIC = 3'd4;
  localparam logic [2:0] ST_BAD_VER   = 3'd5;
  localparam logic [2:0] ST_TRUNC     = 3'd6;

  localparam logic [2:0] REG_FROM_SEQ = 3'd0;
  localparam logic [2:0] REG_MAGIC    = 3'd1;
  localparam logic [2:0] REG_VERSION  = 3'd2;
  localparam logic [2:0] REG_MAX_LEN  = 3'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] sequence_number;
    logic [63:0] time_stamp;
    logic [7:0]  op_code;
    logic [15:0] payload_count;
    logic [2:0]  status;
    logic [31:0] replayed_total;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
  } qwr_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ 32'hEDB88320) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== rtl/lrd_front.sv =====
// front: byte parser that turns each input byte into up to two results
module lrd_front #(
  parameter int MAX_BODY_BYTES = lrd_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         data_byte,
  input  logic               segment_start,
  input  logic               segment_end,
  input  logic [63:0]        seq_floor,
  input  logic [31:0]        segment_magic,
  input  logic [31:0]        segment_version,
  input  logic [16:0]        max_body_length,
  output lrd_pkg::qwr_t      qwr,
  output lrd_pkg::res_t      res0,
  output lrd_pkg::res_t      res1
);
  import lrd_pkg::*;

  localparam int IW = $clog2(MAX_BODY_BYTES + 1);

  phase_t       phase_r, phase_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0]  hw_r, hw_nxt, lw_r, lw_nxt, ce_r, ce_nxt, crc_r, crc_nxt;
  logic [63:0]  seq_r, seq_nxt, tm_r, tm_nxt;
  logic [7:0]   op_r, op_nxt;
  logic         skip_r, skip_nxt;
  logic [31:0]  cnt_r, cnt_nxt;

  logic [1:0]   n;
  res_t         e [2];
  res_t         r;

  function automatic logic mid(input phase_t p, input logic [IW-1:0] i);
    logic m;
    m = 1'b1;
    if (p == PH_IDLE) m = 1'b0;
    if ((p == PH_HDR || p == PH_LEN) && i == '0) m = 1'b0;
    return m;
  endfunction

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    hw_nxt    = hw_r;
    lw_nxt    = lw_r;
    ce_nxt    = ce_r;
    crc_nxt   = crc_r;
    seq_nxt   = seq_r;
    tm_nxt    = tm_r;
    op_nxt    = op_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    n         = 2'd0;
    e[0]      = '0;
    e[1]      = '0;
    r         = '0;

    if (segment_start) begin
      if (mid(phase_nxt, idx_nxt)) begin
        r = '0;
        r.kind = KIND_STOP;
        r.status = ST_TRUNC;
        r.replayed_total = cnt_nxt;
        e[n[0]] = r;
        n = n + 2'd1;
      end
      phase_nxt = PH_HDR;
      idx_nxt   = '0;
      hw_nxt    = '0;
      lw_nxt    = '0;
      ce_nxt    = '0;
      crc_nxt   = '1;
      seq_nxt   = '0;
      tm_nxt    = '0;
      op_nxt    = '0;
      skip_nxt  = 1'b0;
    end

    unique case (phase_nxt)
      PH_HDR: begin
        hw_nxt[{idx_nxt[1:0], 3'b000} +: 8] = hw_nxt[{idx_nxt[1:0], 3'b000} +: 8] | data_byte;
        idx_nxt = idx_nxt + IW'(1);
        if (idx_nxt == IW'(4)) begin
          if (hw_nxt != segment_magic) begin
            r = '0;
            r.kind = KIND_STOP;
            r.status = ST_BAD_MAGIC;
            r.replayed_total = cnt_nxt;
            e[n[0]] = r;
            n = n + 2'd1;
            phase_nxt = PH_IDLE;
            idx_nxt = '0;
          end else begin
            hw_nxt = '0;
          end
        end else if (idx_nxt >= IW'(8)) begin
          if (hw_nxt != segment_version) begin
            r = '0;
            r.kind = KIND_STOP;
            r.status = ST_BAD_VER;
            r.replayed_total = cnt_nxt;
            e[n[0]] = r;
            n = n + 2'd1;
            phase_nxt = PH_IDLE;
            idx_nxt = '0;
          end else begin
            phase_nxt = PH_LEN;
            idx_nxt = '0;
            lw_nxt = '0;
            ce_nxt = '0;
            crc_nxt = '1;
            seq_nxt = '0;
            tm_nxt = '0;
            op_nxt = '0;
            skip_nxt = 1'b0;
          end
        end
      end
      PH_LEN: begin
        lw_nxt[{idx_nxt[1:0], 3'b000} +: 8] = lw_nxt[{idx_nxt[1:0], 3'b000} +: 8] | data_byte;
        idx_nxt = idx_nxt + IW'(1);
        if (idx_nxt >= IW'(4)) begin
          phase_nxt = PH_CRC;
          idx_nxt = '0;
        end
      end
      PH_CRC: begin
        ce_nxt[{idx_nxt[1:0], 3'b000} +: 8] = ce_nxt[{idx_nxt[1:0], 3'b000} +: 8] | data_byte;
        idx_nxt = idx_nxt + IW'(1);
        if (idx_nxt >= IW'(4)) begin
          if (lw_nxt < 32'(RECORD_HEADER_BYTES) || lw_nxt > {15'd0, max_body_length} ||
              lw_nxt > 32'(MAX_BODY_BYTES)) begin
            r = '0;
            r.kind = KIND_STOP;
            r.status = ST_BAD_LEN;
            r.replayed_total = cnt_nxt;
            e[n[0]] = r;
            n = n + 2'd1;
            phase_nxt = PH_IDLE;
            idx_nxt = '0;
          end else begin
            phase_nxt = PH_BODY;
            idx_nxt = '0;
          end
        end
      end
      PH_BODY: begin
        crc_nxt = crc_byte(crc_nxt, data_byte);
        if (idx_nxt < IW'(8)) begin
          seq_nxt[{idx_nxt[2:0], 3'b000} +: 8] = data_byte;
        end else if (idx_nxt < IW'(16)) begin
          tm_nxt[{idx_nxt[2:0], 3'b000} +: 8] = data_byte;
        end else if (idx_nxt == IW'(16)) begin
          op_nxt = data_byte;
          skip_nxt = seq_nxt < seq_floor;
        end else if (!skip_nxt) begin
          r = '0;
          r.kind = KIND_PAYLOAD;
          r.payload_byte = data_byte;
          r.sequence_number = seq_nxt;
          r.time_stamp = tm_nxt;
          r.op_code = op_nxt;
          r.status = ST_OK;
          r.replayed_total = cnt_nxt;
          e[n[0]] = r;
          n = n + 2'd1;
        end
        idx_nxt = idx_nxt + IW'(1);
        if (32'(idx_nxt) >= lw_nxt) begin
          if (~crc_nxt != ce_nxt) begin
            r = '0;
            r.kind = KIND_STOP;
            r.status = ST_CRC;
            r.replayed_total = cnt_nxt;
            e[n[0]] = r;
            n = n + 2'd1;
            phase_nxt = PH_IDLE;
            idx_nxt = '0;
          end else begin
            if (!skip_nxt && cnt_nxt != '1) cnt_nxt = cnt_nxt + 32'd1;
            r = '0;
            r.kind = KIND_RECORD;
            r.sequence_number = seq_nxt;
            r.time_stamp = tm_nxt;
            r.op_code = op_nxt;
            r.payload_count = 16'(lw_nxt - 32'(RECORD_HEADER_BYTES));
            r.status = skip_nxt ? ST_SKIPPED : ST_OK;
            r.replayed_total = cnt_nxt;
            e[n[0]] = r;
            n = n + 2'd1;
            phase_nxt = PH_LEN;
            idx_nxt = '0;
            lw_nxt = '0;
            ce_nxt = '0;
            crc_nxt = '1;
            seq_nxt = '0;
            tm_nxt = '0;
            op_nxt = '0;
            skip_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    if (segment_end) begin
      if (mid(phase_nxt, idx_nxt)) begin
        r = '0;
        r.kind = KIND_STOP;
        r.status = ST_TRUNC;
        r.replayed_total = cnt_nxt;
        e[n[0]] = r;
        n = n + 2'd1;
      end
      phase_nxt = PH_IDLE;
      idx_nxt = '0;
    end

    if (n == 2'd1) e[0].last_of_run = 1'b1;
    if (n == 2'd2) e[1].last_of_run = 1'b1;
  end

  assign qwr.wr0 = take && (n != 2'd0);
  assign qwr.wr1 = take && (n == 2'd2);
  assign res0 = e[0];
  assign res1 = e[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      idx_r   <= '0;
      hw_r    <= '0;
      lw_r    <= '0;
      ce_r    <= '0;
      crc_r   <= '1;
      seq_r   <= '0;
      tm_r    <= '0;
      op_r    <= '0;
      skip_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      hw_r    <= hw_nxt;
      lw_r    <= lw_nxt;
      ce_r    <= ce_nxt;
      crc_r   <= crc_nxt;
      seq_r   <= seq_nxt;
      tm_r    <= tm_nxt;
      op_r    <= op_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/lrd_queue.sv =====
// short result queue between parser and output stage, up to two writes a cycle
module lrd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  lrd_pkg::qwr_t qwr,
  input  lrd_pkg::res_t wdata0,
  input  lrd_pkg::res_t wdata1,
  input  logic          pop,
  output logic          not_empty,
  output logic          room2,
  output lrd_pkg::res_t rdata
);
  import lrd_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  res_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic [PW-1:0] wptr1;

  assign wptr1 = wptr_r + PW'(1);
  assign not_empty = count_r != '0;
  assign room2 = count_r <= (PW+1)'(QUEUE_DEPTH - 2);
  assign rdata = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r + PW'(qwr.wr0) + PW'(qwr.wr1);
    rptr_nxt  = rptr_r + PW'(pop);
    count_nxt = count_r + (PW+1)'(qwr.wr0) + (PW+1)'(qwr.wr1) - (PW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (qwr.wr0) mem_r[wptr_r] <= wdata0;
    if (qwr.wr1) mem_r[wptr1] <= wdata1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/lrd_back.sv =====
// back: output register that hands results to the sink
module lrd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_not_empty,
  input  lrd_pkg::res_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output lrd_pkg::res_t out_res
);
  import lrd_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign q_pop = q_not_empty && (!valid_r || out_ready);
  assign valid_nxt = q_pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= q_data;
  end

endmodule

// ===== rtl/log_record_deframer_crc32.sv =====
// Log record deframer: takes one segment byte per cycle (tuser marks segment start, tlast
// segment end), checks the 8-byte segment header, parses length/crc-prefixed records and
// streams payload bytes with a record verdict or a segment stop verdict (kind in tuser).
// A byte is taken every cycle while the four-entry result queue has room for two results;
// the crc is updated one byte per cycle. Results leave through a registered output stage,
// one per cycle while the sink is ready. Registers sit at byte addresses 0, 8, 16, 24.
module log_record_deframer_crc32 #(
  parameter int MAX_BODY_BYTES = lrd_pkg::MAX_BODY_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tuser,   // segment_start
  input  logic         in_tlast,   // segment_end
  output logic         out_tvalid,
  input  logic         out_tready,
  // payload_byte, sequence_number, time_stamp, op_code, payload_count, status,
  // replayed_total, zero pad
  output logic [199:0] out_tdata,
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast,  // last_of_run
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);
  import lrd_pkg::*;

  logic [63:0] from_seq_r;
  logic [31:0] magic_r, version_r;
  logic [16:0] max_len_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  qwr_t qwr;
  res_t res0, res1, q_data, o_res;
  logic q_not_empty, q_room2, q_pop, take;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = {1'b0, cfg_paddr[4:3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      from_seq_r <= '0;
      magic_r    <= '0;
      version_r  <= 32'd1;
      max_len_r  <= 17'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FROM_SEQ: from_seq_r <= cfg_pwdata;
        REG_MAGIC:    magic_r <= cfg_pwdata[31:0];
        REG_VERSION:  version_r <= cfg_pwdata[31:0];
        REG_MAX_LEN:  max_len_r <= cfg_pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FROM_SEQ: cfg_prdata = from_seq_r;
      REG_MAGIC:    cfg_prdata = {32'd0, magic_r};
      REG_VERSION:  cfg_prdata = {32'd0, version_r};
      REG_MAX_LEN:  cfg_prdata = {47'd0, max_len_r};
      default:      cfg_prdata = '0;
    endcase
  end

  assign in_tready = q_room2;
  assign take = in_tvalid && q_room2;

  lrd_front #(.MAX_BODY_BYTES(MAX_BODY_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take),
    .data_byte(in_tdata), .segment_start(in_tuser), .segment_end(in_tlast),
    .seq_floor(from_seq_r), .segment_magic(magic_r),
    .segment_version(version_r), .max_body_length(max_len_r),
    .qwr(qwr), .res0(res0), .res1(res1)
  );

  lrd_queue u_queue (
    .clk(clk), .rst_n(rst_n), .qwr(qwr), .wdata0(res0), .wdata1(res1),
    .pop(q_pop), .not_empty(q_not_empty), .room2(q_room2), .rdata(q_data)
  );

  lrd_back u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_data(q_data),
    .q_pop(q_pop), .out_valid(out_tvalid), .out_ready(out_tready), .out_res(o_res)
  );

  assign out_tdata = {5'd0, o_res.replayed_total, o_res.status, o_res.payload_count,
                      o_res.op_code, o_res.time_stamp, o_res.sequence_number,
                      o_res.payload_byte};
  assign out_tuser = o_res.kind;
  assign out_tlast = o_res.last_of_run;

  a_kind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_PAYLOAD || out_tuser == KIND_RECORD ||
                    out_tuser == KIND_STOP))
    else $error("undefined result kind");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_PAYLOAD |-> out_tdata[162:160] == ST_OK)
    else $error("payload result with status");

  a_stop_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_STOP |-> out_tdata[159:0] == '0)
    else $error("stop result carries record fields");

  a_reset_idle: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

endmodule
